[sv/balance_cascade_pd_pi_controller_top_assert.svh]
// Assertion macros used by the balance controller sequencer.
`ifndef BALANCE_CASCADE_PD_PI_CONTROLLER_TOP_ASSERT_SVH
`define BALANCE_CASCADE_PD_PI_CONTROLLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCPP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bcpp_pkg.sv]
// Types, constants and codes for the balance controller.
package bcpp_pkg;

    localparam int DRIVE_WIDTH = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 14;
    localparam int TILT_W   = 15;
    localparam int ERR_W    = 18;
    localparam int INTEG_W  = 15;
    localparam int NUM_W    = 22;
    localparam int MAG_W    = 21;
    localparam int PROD_W   = GAIN_W + ERR_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DIFF_W   = ACC_W + 1;

    // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every x below 2^22
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP10 = 20'd838861;

    localparam logic signed [SAMPLE_W-1:0] RST_BALANCE_ANGLE = 16'sd0;
    localparam logic signed [GAIN_W-1:0]   RST_TILT_GAIN     = 24'sd80640;
    localparam logic signed [GAIN_W-1:0]   RST_RATE_GAIN     = -24'sd1280;
    localparam logic signed [GAIN_W-1:0]   RST_SPEED_GAIN    = -24'sd19200;
    localparam logic signed [GAIN_W-1:0]   RST_SPEED_I_GAIN  = -24'sd90;
    localparam logic [TILT_W-1:0]          RST_TILT_CUTOFF   = 15'd7680;
    localparam logic [LIMIT_W-1:0]         RST_INTEG_LIMIT   = 14'd10000;
    localparam logic [TILT_W-1:0]          RST_INTEG_RST_TILT = 15'd10240;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BALANCE_ANGLE,
        REG_TILT_GAIN,
        REG_RATE_GAIN,
        REG_SPEED_GAIN,
        REG_SPEED_I_GAIN,
        REG_TILT_CUTOFF,
        REG_INTEG_LIMIT,
        REG_INTEG_RST_TILT
    } bcpp_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] balance_angle;
        logic signed [GAIN_W-1:0]   tilt_gain;
        logic signed [GAIN_W-1:0]   rate_gain;
        logic signed [GAIN_W-1:0]   speed_gain;
        logic signed [GAIN_W-1:0]   speed_integral_gain;
        logic [TILT_W-1:0]          tilt_cutoff;
        logic [LIMIT_W-1:0]         integral_limit;
        logic [TILT_W-1:0]          integral_reset_tilt;
    } bcpp_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NUM,
        ST_DIV,
        ST_INTEG,
        ST_MUL_SPD,
        ST_MUL_INT,
        ST_MUL_TILT,
        ST_MUL_RATE,
        ST_PD,
        ST_DONE
    } bcpp_state_t;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_INTEG,
        MUL_TILT,
        MUL_RATE
    } bcpp_mul_t;

    typedef struct packed {
        logic      load;
        logic      num_en;
        logic      div_en;
        logic      integ_en;
        logic      mul_en;
        bcpp_mul_t mul_sel;
        logic      acc_en;
        logic      pi_en;
        logic      pd_en;
        logic      commit;
    } bcpp_cmd_t;

endpackage

[sv/balance_cascade_pd_pi_controller_top.sv]
// Ticks are taken one at a time: a new tick is accepted only once the last result is
// committed. The sequencer steps filter, divide, integrate and four passes of the one
// gain multiplier, then holds in its done step until the output register is free.
// A result waits in the output register while the next tick is accepted.
// Reset (synchronous, active low) restores register defaults and clears filter and integral.
module balance_cascade_pd_pi_controller_top
    import bcpp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_tilt_angle,
    input  logic signed [SAMPLE_W-1:0] s_gyro_rate,
    input  logic signed [SAMPLE_W-1:0] s_left_count,
    input  logic signed [SAMPLE_W-1:0] s_right_count,
    input  logic signed [SAMPLE_W-1:0] s_speed_ref,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [DRIVE_WIDTH-1:0]     m_left_drive,
    output logic [DRIVE_WIDTH-1:0]     m_right_drive,
    output logic                       m_fallen
);

    bcpp_cfg_t              cfg;
    bcpp_cmd_t              cmd;
    logic [DRIVE_WIDTH-1:0] drive;

    bcpp_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bcpp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg         (cfg),
        .tilt_angle  (s_tilt_angle),
        .gyro_rate   (s_gyro_rate),
        .left_count  (s_left_count),
        .right_count (s_right_count),
        .speed_ref   (s_speed_ref),
        .drive       (drive),
        .fallen      (m_fallen)
    );

    // No steering term: both motors get the same drive
    assign m_left_drive  = drive;
    assign m_right_drive = drive;

endmodule

[sv/bcpp_regs.sv]
// Configuration register file of the balance controller.
module bcpp_regs
    import bcpp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bcpp_cfg_t             cfg
);

    bcpp_cfg_t cfg_reg;
    bcpp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // Truncate write data to the width of the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (bcpp_reg_t'(cfg_index))
                REG_BALANCE_ANGLE:  cfg_next.balance_angle       = cfg_data[SAMPLE_W-1:0];
                REG_TILT_GAIN:      cfg_next.tilt_gain           = cfg_data[GAIN_W-1:0];
                REG_RATE_GAIN:      cfg_next.rate_gain           = cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN:     cfg_next.speed_gain          = cfg_data[GAIN_W-1:0];
                REG_SPEED_I_GAIN:   cfg_next.speed_integral_gain = cfg_data[GAIN_W-1:0];
                REG_TILT_CUTOFF:    cfg_next.tilt_cutoff         = cfg_data[TILT_W-1:0];
                REG_INTEG_LIMIT:    cfg_next.integral_limit      = cfg_data[LIMIT_W-1:0];
                REG_INTEG_RST_TILT: cfg_next.integral_reset_tilt = cfg_data[TILT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.balance_angle       <= RST_BALANCE_ANGLE;
            cfg_reg.tilt_gain           <= RST_TILT_GAIN;
            cfg_reg.rate_gain           <= RST_RATE_GAIN;
            cfg_reg.speed_gain          <= RST_SPEED_GAIN;
            cfg_reg.speed_integral_gain <= RST_SPEED_I_GAIN;
            cfg_reg.tilt_cutoff         <= RST_TILT_CUTOFF;
            cfg_reg.integral_limit      <= RST_INTEG_LIMIT;
            cfg_reg.integral_reset_tilt <= RST_INTEG_RST_TILT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/bcpp_ctrl.sv]
// Sequencer of the balance controller: steps the datapath once per tick.
module bcpp_ctrl
    import bcpp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output bcpp_cmd_t cmd
);

`include "balance_cascade_pd_pi_controller_top_assert.svh"

    bcpp_state_t state_reg;
    bcpp_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_SPEED;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                cmd.num_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ_en = 1'b1;
                state_next   = ST_MUL_SPD;
            end
            ST_MUL_SPD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPEED;
                state_next  = ST_MUL_INT;
            end
            ST_MUL_INT: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                state_next  = ST_MUL_TILT;
            end
            ST_MUL_TILT: begin
                cmd.pi_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TILT;
                state_next  = ST_MUL_RATE;
            end
            ST_MUL_RATE: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE;
                state_next  = ST_PD;
            end
            ST_PD: begin
                cmd.pd_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on commit, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `BCPP_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == ST_NUM,
        "accepted tick did not start the sequence")
    `BCPP_ASSERT_SAME(a_valid_from_done, $rose(m_valid_reg), $past(state_reg == ST_DONE),
        "result valid raised outside the done step")
    `BCPP_ASSERT_SAME(a_commit_free, cmd.commit, !m_valid_reg || m_ready,
        "result committed over an untaken result")
    `BCPP_ASSERT_NEXT(a_done_holds, state_reg == ST_DONE && m_valid_reg && !m_ready,
        state_reg == ST_DONE, "done step left while output blocked")

endmodule

[sv/bcpp_dp.sv]
// Datapath of the balance controller: filter, integral, shared multiplier, drive.
module bcpp_dp
    import bcpp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bcpp_cmd_t                  cmd,
    input  bcpp_cfg_t                  cfg,
    input  logic signed [SAMPLE_W-1:0] tilt_angle,
    input  logic signed [SAMPLE_W-1:0] gyro_rate,
    input  logic signed [SAMPLE_W-1:0] left_count,
    input  logic signed [SAMPLE_W-1:0] right_count,
    input  logic signed [SAMPLE_W-1:0] speed_ref,
    output logic [DRIVE_WIDTH-1:0]     drive,
    output logic                       fallen
);

    localparam int PI_SHIFT = 8;
    localparam int PD_SHIFT = 16;
    localparam logic signed [DIFF_W-1:0] DRIVE_MAX =
        DIFF_W'((64'sd1 <<< (DRIVE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [DIFF_W-1:0] DRIVE_MIN = -DRIVE_MAX - DIFF_W'(1);
    localparam logic signed [ACC_W-1:0] PI_BIAS =
        ACC_W'((64'sd1 <<< PI_SHIFT) - 64'sd1);
    localparam logic signed [ACC_W-1:0] PD_BIAS =
        ACC_W'((64'sd1 <<< PD_SHIFT) - 64'sd1);
    localparam logic signed [ACC_W-1:0] NO_BIAS = ACC_W'(0);

    // Latched tick inputs
    logic signed [SAMPLE_W-1:0] tilt_reg, gyro_reg, enc_l_reg, enc_r_reg, target_reg;

    // Loop state
    logic signed [ERR_W-1:0]   filt_state_reg;
    logic signed [INTEG_W-1:0] integ_state_reg;

    // Working registers
    logic                      num_neg_reg;
    logic [MAG_W-1:0]          num_mag_reg;
    logic signed [ERR_W-1:0]   filt_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   pi_reg;
    logic signed [ACC_W-1:0]   pd_reg;
    logic [DRIVE_WIDTH-1:0]    drive_reg;
    logic                      fallen_reg;

    logic signed [ERR_W-1:0]   err;
    logic signed [NUM_W-1:0]   num;
    logic signed [NUM_W-1:0]   num_abs;
    logic [MAG_W+RECIP_W-1:0]  q_prod;
    logic [ERR_W-1:0]          q;
    logic signed [ERR_W-1:0]   filt_next;
    logic signed [ERR_W:0]     isum;
    logic signed [ERR_W:0]     ilim;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [ERR_W-1:0]   mul_b;
    logic signed [SAMPLE_W:0]  dtilt;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   pi_next;
    logic signed [ACC_W-1:0]   pd_next;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  sat;
    logic signed [SAMPLE_W:0]  tilt_ext;
    logic [SAMPLE_W:0]         tilt_mag;
    logic                      fallen_next;
    logic                      clear_next;
    logic [DRIVE_WIDTH-1:0]    drive_next;

    // Speed error and filter numerator 3*err + 7*last
    always_comb begin
        err = ERR_W'(enc_r_reg) - ERR_W'(enc_l_reg) - ERR_W'(target_reg);
        num = NUM_W'(err) * 22'sd3 + NUM_W'(filt_state_reg) * 22'sd7;
        num_abs = num[NUM_W-1] ? -num : num;
    end

    // Divide magnitude by ten through the reciprocal, then restore the sign
    always_comb begin
        q_prod    = num_mag_reg * RECIP10;
        q         = q_prod[RECIP_SHIFT +: ERR_W];
        filt_next = num_neg_reg ? -$signed(q) : $signed(q);
    end

    // Integrate and clamp to the symmetric limit
    always_comb begin
        isum = (ERR_W+1)'(integ_state_reg) + (ERR_W+1)'(filt_reg);
        ilim = $signed((ERR_W+1)'(cfg.integral_limit));
        if (isum < -ilim) begin
            integ_next = INTEG_W'(-ilim);
        end else if (isum > ilim) begin
            integ_next = INTEG_W'(ilim);
        end else begin
            integ_next = INTEG_W'(isum);
        end
    end

    // Shared gain multiplier operands
    always_comb begin
        dtilt = (SAMPLE_W+1)'(tilt_reg) - (SAMPLE_W+1)'(cfg.balance_angle);
        case (cmd.mul_sel)
            MUL_SPEED: begin
                mul_a = cfg.speed_gain;
                mul_b = filt_reg;
            end
            MUL_INTEG: begin
                mul_a = cfg.speed_integral_gain;
                mul_b = ERR_W'(integ_reg);
            end
            MUL_TILT: begin
                mul_a = cfg.tilt_gain;
                mul_b = ERR_W'(dtilt);
            end
            MUL_RATE: begin
                mul_a = cfg.rate_gain;
                mul_b = ERR_W'(gyro_reg);
            end
            default: begin
                mul_a = cfg.speed_gain;
                mul_b = filt_reg;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Sum the two products and shift with truncation toward zero
    always_comb begin
        sum     = acc_reg + ACC_W'(prod_reg);
        pi_next = (sum + (sum[ACC_W-1] ? PI_BIAS : NO_BIAS)) >>> PI_SHIFT;
        pd_next = (sum + (sum[ACC_W-1] ? PD_BIAS : NO_BIAS)) >>> PD_SHIFT;
    end

    // Saturate the drive and apply the tilt cutoff
    always_comb begin
        diff = DIFF_W'(pd_reg) - DIFF_W'(pi_reg);
        if (diff > DRIVE_MAX) begin
            sat = DRIVE_MAX;
        end else if (diff < DRIVE_MIN) begin
            sat = DRIVE_MIN;
        end else begin
            sat = diff;
        end
        tilt_ext    = (SAMPLE_W+1)'(tilt_reg);
        tilt_mag    = tilt_ext[SAMPLE_W] ? (SAMPLE_W+1)'(-tilt_ext) : (SAMPLE_W+1)'(tilt_ext);
        fallen_next = tilt_mag > (SAMPLE_W+1)'(cfg.tilt_cutoff);
        clear_next  = tilt_mag > (SAMPLE_W+1)'(cfg.integral_reset_tilt);
        drive_next  = fallen_next ? '0 : sat[DRIVE_WIDTH-1:0];
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tilt_reg   <= tilt_angle;
            gyro_reg   <= gyro_rate;
            enc_l_reg  <= left_count;
            enc_r_reg  <= right_count;
            target_reg <= speed_ref;
        end
        if (cmd.num_en) begin
            num_neg_reg <= num[NUM_W-1];
            num_mag_reg <= num_abs[MAG_W-1:0];
        end
        if (cmd.div_en) begin
            filt_reg <= filt_next;
        end
        if (cmd.integ_en) begin
            integ_reg <= integ_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_en) begin
            acc_reg <= ACC_W'(prod_reg);
        end
        if (cmd.pi_en) begin
            pi_reg <= pi_next;
        end
        if (cmd.pd_en) begin
            pd_reg <= pd_next;
        end
        if (cmd.commit) begin
            drive_reg  <= drive_next;
            fallen_reg <= fallen_next;
        end
    end

    // Loop state: filter memory and integral, the integral cleared past the reset tilt
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_state_reg  <= '0;
            integ_state_reg <= '0;
        end else if (cmd.commit) begin
            filt_state_reg  <= filt_reg;
            integ_state_reg <= clear_next ? '0 : integ_reg;
        end
    end

    assign drive  = drive_reg;
    assign fallen = fallen_reg;

endmodule
